>>> sv/lvsd_pkg.sv
// Shared types and constants for the dirty-aware LRU victim selector.
// Used by every module of the block; depends on nothing.
package lvsd_pkg;

    localparam int WAYS  = 8;
    localparam int AGE_W = $clog2(WAYS);
    localparam int CNT_W = $clog2(WAYS + 1);
    localparam int THR_W = 4;

    localparam logic [THR_W-1:0] CKPT_COUNT_RESET = 4'd9;

    typedef logic [2:0]       way_t;
    typedef logic [AGE_W-1:0] age_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [THR_W-1:0] thr_t;
    typedef logic [7:0]       mask_t;

    typedef enum logic
    {
        CMD_REPLACE = 1'b0,
        CMD_TOUCH   = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        KIND_INVALID = 2'd0,
        KIND_CLEAN   = 2'd1,
        KIND_CKPT    = 2'd2,
        KIND_TOUCH   = 2'd3
    } kind_t;

    typedef struct packed
    {
        cmd_t  cmd;
        way_t  touch_way;
        mask_t valid_mask;
        mask_t modified_mask;
        mask_t upgrading_mask;
    } req_item_t;

    typedef struct packed
    {
        way_t  victim_way;
        kind_t victim_kind;
    } rsp_item_t;

    // Request to make one way most recently used.
    typedef struct packed
    {
        logic en;
        way_t way;
    } upd_t;

endpackage

>>> sv/lru_victim_select_dirty_aware.sv
// Top level of the dirty-aware LRU victim selector for one cache set.
// Depends on lvsd_pkg, lvsd_select and lvsd_ages.
//
// Usage:
//   req channel (req_valid, req_stall, req): a replacement request or a
//   touch. The item is taken at an edge with req_valid high and req_stall
//   low, and lands in an input register.
//   rsp channel (rsp_valid, rsp_stall, rsp): one result item per request,
//   in request order, held in a result register until rsp_stall is low.
//   cfg channel (cfg_valid, cfg_ready, cfg_data): writes the checkpoint
//   count; write it only while no request is in flight.
// The result register loads from the input register once it is free, so a
// stalled result delays rsp_valid. One item per cycle is sustained while the
// receiver does not stall: the choice over the eight ways is a single
// combinational pass between the input and result registers, and the ages
// update on the same edge, so the next request sees them at once.
// Reset gives way i the age i and sets the checkpoint count to 9 (never).
// When the receiver stalls, the result holds and one more request can wait
// in the input register; then req_stall rises until the result is taken.
module lru_victim_select_dirty_aware
    import lvsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  thr_t      cfg_data
);

    req_item_t s1_item_reg;
    logic      s1_valid_reg;
    logic      s1_valid_next;
    rsp_item_t rsp_reg;
    logic      rsp_valid_reg;
    logic      rsp_valid_next;
    thr_t      thr_reg;

    logic      out_free;
    logic      advance;
    logic      req_take;
    rsp_item_t sel_rsp;
    upd_t      sel_upd;
    upd_t      age_upd;
    age_t      ages [WAYS];

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign advance   = s1_valid_reg && out_free;
    assign req_stall = s1_valid_reg && !out_free;
    assign req_take  = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    assign s1_valid_next  = req_take || (s1_valid_reg && !advance);
    assign rsp_valid_next = advance || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            thr_reg       <= CKPT_COUNT_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
                thr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
            s1_item_reg <= req;
        if (advance)
            rsp_reg <= sel_rsp;
    end

    lvsd_select u_select
    (
        .item       (s1_item_reg),
        .ages       (ages),
        .ckpt_count (thr_reg),
        .rsp        (sel_rsp),
        .upd        (sel_upd)
    );

    // Ages change only when the request actually moves to the result register.
    assign age_upd = '{en: sel_upd.en && advance, way: sel_upd.way};

    lvsd_ages u_ages
    (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (age_upd),
        .ages  (ages)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> sv/lvsd_ages.sv
// Per-way LRU age registers with the make-MRU update.
// Depends on lvsd_pkg.
module lvsd_ages
    import lvsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  upd_t upd,
    output age_t ages [WAYS]
);

    age_t age_reg  [WAYS];
    age_t age_next [WAYS];

    always_comb
    begin
        age_t hit_age;
        hit_age = age_reg[upd.way];
        for (int j = 0; j < WAYS; j++)
        begin
            age_next[j] = age_reg[j];
            if (upd.en)
            begin
                if (way_t'(j) == upd.way)
                    age_next[j] = '0;
                else if (age_reg[j] < hit_age)
                    age_next[j] = age_reg[j] + age_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < WAYS; j++)
                age_reg[j] <= age_t'(j);
        end
        else
        begin
            age_reg <= age_next;
        end
    end

    assign ages = age_reg;

endmodule

>>> sv/lvsd_select.sv
// Combinational victim choice for one registered request.
// Depends on lvsd_pkg; reads the current ages and the threshold register.
module lvsd_select
    import lvsd_pkg::*;
(
    input  req_item_t item,
    input  age_t      ages [WAYS],
    input  thr_t      ckpt_count,
    output rsp_item_t rsp,
    output upd_t      upd
);

    logic inv_found;
    way_t inv_way;
    cnt_t nmod;
    age_t best;
    way_t pick;
    logic old_found;
    way_t old_way;

    always_comb
    begin
        inv_found = 1'b0;
        inv_way   = '0;
        nmod      = '0;
        best      = '0;
        pick      = '0;
        old_found = 1'b0;
        old_way   = '0;

        // Scan downward so the lowest-numbered hit wins.
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (!item.valid_mask[i])
            begin
                inv_found = 1'b1;
                inv_way   = way_t'(i);
            end
            if (ages[i] == age_t'(WAYS - 1))
            begin
                old_found = 1'b1;
                old_way   = way_t'(i);
            end
        end

        // Strictly greater keeps the lowest index on ties.
        for (int i = 0; i < WAYS; i++)
        begin
            if (item.modified_mask[i])
                nmod = nmod + cnt_t'(1);
            if (!item.modified_mask[i] && !item.upgrading_mask[i] && ages[i] > best)
            begin
                best = ages[i];
                pick = way_t'(i);
            end
        end
    end

    always_comb
    begin
        if (item.cmd == CMD_TOUCH)
        begin
            rsp.victim_way  = item.touch_way;
            rsp.victim_kind = KIND_TOUCH;
            upd.en          = (32'(item.touch_way) < WAYS);
            upd.way         = item.touch_way;
        end
        else if (inv_found)
        begin
            rsp.victim_way  = inv_way;
            rsp.victim_kind = KIND_INVALID;
            upd.en          = 1'b1;
            upd.way         = inv_way;
        end
        else if (32'(nmod) >= 32'(ckpt_count) && old_found)
        begin
            rsp.victim_way  = old_way;
            rsp.victim_kind = KIND_CKPT;
            upd.en          = 1'b0;
            upd.way         = old_way;
        end
        else
        begin
            rsp.victim_way  = pick;
            rsp.victim_kind = KIND_CLEAN;
            upd.en          = 1'b1;
            upd.way         = pick;
        end
    end

endmodule

>>> sv/lvsd_checker.sv
// Port-level checks for the dirty-aware LRU victim selector.
// Depends on lvsd_pkg; bound to lru_victim_select_dirty_aware below.
module lvsd_checker
    import lvsd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input req_item_t req,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input rsp_item_t rsp
);

    // A stalled result item holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result item changed");

    // Every accepted item is followed by a valid result.
    a_req_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |-> ##2 rsp_valid)
        else $error("no result two cycles after an accepted item");

    // Back pressure on requests comes only from a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("request stalled without a stalled result");

    // A result item shows up on an empty output only after a request was taken.
    a_rsp_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid ##1 rsp_valid |-> $past(req_valid && !req_stall, 2))
        else $error("result item without an accepted request");

endmodule

bind lru_victim_select_dirty_aware lvsd_checker u_lvsd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
